// ===== design/stt_pkg.sv =====
// Shared types, token codes and character classes of the source text tokenizer.
package stt_pkg;

   localparam int OFFSET_BITS_DEFAULT       = 16;
   localparam int KEYWORD_MAX_CHARS_DEFAULT = 6;

   // Number of keyword bytes that the keyword compare looks at.
   localparam int KW_CHARS = 6;
   localparam int KW_COUNT = 10;

   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_IDENT  = 2'd1;
   localparam logic [1:0] MODE_NUMBER = 2'd2;
   localparam logic [1:0] MODE_STRING = 2'd3;

   localparam logic [4:0] TOK_IDENT   = 5'd0;
   localparam logic [4:0] TOK_NUMBER  = 5'd1;
   localparam logic [4:0] TOK_STRING  = 5'd2;
   localparam logic [4:0] TOK_PLUS    = 5'd3;
   localparam logic [4:0] TOK_MINUS   = 5'd4;
   localparam logic [4:0] TOK_STAR    = 5'd5;
   localparam logic [4:0] TOK_SLASH   = 5'd6;
   localparam logic [4:0] TOK_EQUAL   = 5'd7;
   localparam logic [4:0] TOK_LPAREN  = 5'd8;
   localparam logic [4:0] TOK_RPAREN  = 5'd9;
   localparam logic [4:0] TOK_LBRACE  = 5'd10;
   localparam logic [4:0] TOK_RBRACE  = 5'd11;
   localparam logic [4:0] TOK_COLON   = 5'd12;
   localparam logic [4:0] TOK_SEMI    = 5'd13;
   localparam logic [4:0] TOK_COMMA   = 5'd14;
   localparam logic [4:0] TOK_DOT     = 5'd15;
   localparam logic [4:0] TOK_KEYWORD = 5'd16;
   localparam logic [4:0] TOK_END     = 5'd26;

   // Keyword text, first character in the low byte, unused bytes zero.
   localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
      48'h0000_0074_656C,   // let
      48'h0074_736E_6F63,   // const
      48'h0000_0066_6564,   // def
      48'h0000_0000_6669,   // if
      48'h0000_6573_6C65,   // else
      48'h0000_0072_6F66,   // for
      48'h0065_6C69_6877,   // while
      48'h6E72_7574_6572,   // return
      48'h0073_7361_6C63,   // class
      48'h0074_6E69_7270    // print
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd3, 3'd5, 3'd3, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd5, 3'd5
   };

   typedef struct packed {
      logic [4:0]  token_type;
      logic [15:0] start_offset;
      logic [15:0] text_length;
   } tok_item_type;

   typedef struct packed {
      logic [1:0]             count;
      tok_item_type [2:0]     slot;
   } scan_out_type;

   typedef struct packed {
      tok_item_type tok;
      logic         last;
   } rsp_item_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] code;
   } punct_type;

   function automatic logic is_letter(logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == 8'h5F;
   endfunction

   function automatic logic is_digit(logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   function automatic logic is_space(logic [7:0] b);
      return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic punct_type punct_lookup(logic [7:0] b);
      punct_type p;
      p.hit = 1'b1;
      case (b)
         8'h2B: p.code = TOK_PLUS;
         8'h2D: p.code = TOK_MINUS;
         8'h2A: p.code = TOK_STAR;
         8'h2F: p.code = TOK_SLASH;
         8'h3D: p.code = TOK_EQUAL;
         8'h28: p.code = TOK_LPAREN;
         8'h29: p.code = TOK_RPAREN;
         8'h7B: p.code = TOK_LBRACE;
         8'h7D: p.code = TOK_RBRACE;
         8'h3A: p.code = TOK_COLON;
         8'h3B: p.code = TOK_SEMI;
         8'h2C: p.code = TOK_COMMA;
         8'h2E: p.code = TOK_DOT;
         default: begin
            p.hit  = 1'b0;
            p.code = TOK_IDENT;
         end
      endcase
      return p;
   endfunction

   // Bytes past the word length are always zero, so a whole-word compare works.
   function automatic logic [4:0] word_type(logic [47:0] text, logic [2:0] len);
      logic [4:0] code;
      code = TOK_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (text == KW_TEXT[k] && len == KW_LEN[k]) begin
            code = TOK_KEYWORD + 5'(k);
         end
      end
      return code;
   endfunction

endpackage

// ===== design/stt_scan.sv =====
// Scanner state and per-item token generation of the source text tokenizer.
module stt_scan #(
   parameter int OFFSET_BITS       = stt_pkg::OFFSET_BITS_DEFAULT,
   parameter int KEYWORD_MAX_CHARS = stt_pkg::KEYWORD_MAX_CHARS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           byte_value,
   input  logic                 has_byte,
   input  logic                 end_of_source,
   output stt_pkg::scan_out_type result
);

   localparam int LANE_BITS = $clog2(KEYWORD_MAX_CHARS);
   localparam logic [OFFSET_BITS-1:0] OFS_MAX = {OFFSET_BITS{1'b1}};

   logic [1:0]                              mode_ff, mode_in;
   logic [OFFSET_BITS-1:0]                  ofs_ff, ofs_in;
   logic [OFFSET_BITS-1:0]                  start_ff, start_in;
   logic [KEYWORD_MAX_CHARS-1:0][7:0]       kbuf_ff, kbuf_in;
   logic [2:0]                              wl_ff, wl_in;

   function automatic logic [15:0] to16(logic [OFFSET_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[15:0];
   endfunction

   function automatic logic [OFFSET_BITS-1:0] span(logic [OFFSET_BITS-1:0] a,
                                                   logic [OFFSET_BITS-1:0] b);
      return (a >= b) ? a - b : '0;
   endfunction

   always_comb begin
      logic [1:0]                        mode_mid;
      logic [OFFSET_BITS-1:0]            ofs_mid;
      logic [OFFSET_BITS-1:0]            start_mid;
      logic [KEYWORD_MAX_CHARS-1:0][7:0] kbuf_mid;
      logic [2:0]                        wl_mid;
      logic                              taken;
      logic [3:0]                        cand_v;
      stt_pkg::tok_item_type             cand [4];
      stt_pkg::punct_type                p;
      logic [2:0]                        n;

      mode_mid  = mode_ff;
      ofs_mid   = ofs_ff;
      start_mid = start_ff;
      kbuf_mid  = kbuf_ff;
      wl_mid    = wl_ff;
      taken     = 1'b0;
      cand_v    = '0;
      for (int i = 0; i < 4; i++) begin
         cand[i] = '0;
      end
      p = stt_pkg::punct_lookup(byte_value);

      if (has_byte) begin
         case (mode_ff)
            stt_pkg::MODE_IDENT: begin
               if (stt_pkg::is_letter(byte_value) || stt_pkg::is_digit(byte_value)) begin
                  taken = 1'b1;
                  if ({1'b0, wl_ff} < 4'(KEYWORD_MAX_CHARS)) begin
                     kbuf_mid[wl_ff[LANE_BITS-1:0]] = byte_value;
                  end
                  if (wl_ff != 3'd7) begin
                     wl_mid = wl_ff + 3'd1;
                  end
               end else begin
                  cand_v[0] = 1'b1;
                  cand[0]   = '{stt_pkg::word_type(kbuf_ff[stt_pkg::KW_CHARS-1:0], wl_ff),
                                to16(start_ff), to16(span(ofs_ff, start_ff))};
                  mode_mid  = stt_pkg::MODE_IDLE;
               end
            end
            stt_pkg::MODE_NUMBER: begin
               if (stt_pkg::is_digit(byte_value)) begin
                  taken = 1'b1;
               end else begin
                  cand_v[0] = 1'b1;
                  cand[0]   = '{stt_pkg::TOK_NUMBER, to16(start_ff),
                                to16(span(ofs_ff, start_ff))};
                  mode_mid  = stt_pkg::MODE_IDLE;
               end
            end
            stt_pkg::MODE_STRING: begin
               taken = 1'b1;
               if (byte_value == 8'h22) begin
                  cand_v[0] = 1'b1;
                  cand[0]   = '{stt_pkg::TOK_STRING, to16(start_ff),
                                to16(span(ofs_ff, start_ff))};
                  mode_mid  = stt_pkg::MODE_IDLE;
               end
            end
            default: begin
            end
         endcase

         if (!taken && !stt_pkg::is_space(byte_value)) begin
            if (stt_pkg::is_letter(byte_value)) begin
               mode_mid    = stt_pkg::MODE_IDENT;
               start_mid   = ofs_ff;
               kbuf_mid    = '0;
               kbuf_mid[0] = byte_value;
               wl_mid      = 3'd1;
            end else if (stt_pkg::is_digit(byte_value)) begin
               mode_mid  = stt_pkg::MODE_NUMBER;
               start_mid = ofs_ff;
            end else if (byte_value == 8'h22) begin
               mode_mid  = stt_pkg::MODE_STRING;
               start_mid = (ofs_ff != OFS_MAX) ? ofs_ff + OFFSET_BITS'(1) : OFS_MAX;
            end else if (p.hit) begin
               cand_v[1] = 1'b1;
               cand[1]   = '{p.code, to16(ofs_ff), 16'd1};
            end
         end

         if (ofs_ff != OFS_MAX) begin
            ofs_mid = ofs_ff + OFFSET_BITS'(1);
         end
      end

      if (end_of_source) begin
         if (mode_mid != stt_pkg::MODE_IDLE) begin
            cand_v[2] = 1'b1;
            case (mode_mid)
               stt_pkg::MODE_IDENT:
                  cand[2].token_type = stt_pkg::word_type(
                     kbuf_mid[stt_pkg::KW_CHARS-1:0], wl_mid);
               stt_pkg::MODE_NUMBER: cand[2].token_type = stt_pkg::TOK_NUMBER;
               default:              cand[2].token_type = stt_pkg::TOK_STRING;
            endcase
            cand[2].start_offset = to16(start_mid);
            cand[2].text_length  = to16(span(ofs_mid, start_mid));
         end
         cand_v[3] = 1'b1;
         cand[3]   = '{stt_pkg::TOK_END, to16(ofs_mid), 16'd0};
      end

      // Pack the produced tokens into the low slots, in stream order.
      result = '0;
      n      = '0;
      for (int i = 0; i < 4; i++) begin
         if (cand_v[i]) begin
            if (n < 3'd3) begin
               result.slot[n[1:0]] = cand[i];
            end
            n = n + 3'd1;
         end
      end
      result.count = n[1:0];

      if (end_of_source) begin
         mode_in  = stt_pkg::MODE_IDLE;
         ofs_in   = '0;
         start_in = '0;
         kbuf_in  = '0;
         wl_in    = '0;
      end else begin
         mode_in  = mode_mid;
         ofs_in   = ofs_mid;
         start_in = start_mid;
         kbuf_in  = kbuf_mid;
         wl_in    = wl_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= stt_pkg::MODE_IDLE;
         ofs_ff   <= '0;
         start_ff <= '0;
         kbuf_ff  <= '0;
         wl_ff    <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         ofs_ff   <= ofs_in;
         start_ff <= start_in;
         kbuf_ff  <= kbuf_in;
         wl_ff    <= wl_in;
      end
   end

endmodule

// ===== design/source_text_tokenizer.sv =====
// Top level of the source text tokenizer: scanner plus result queue.
//
//   Channel | Direction | Ports                                     | Item moves when
//   --------+-----------+-------------------------------------------+------------------------
//   req     | in        | req_byte_value, req_has_byte,             | req_valid && req_ready
//           |           | req_end_of_source                         |
//   rsp     | out       | rsp_token_type, rsp_start_offset,         | rsp_valid && rsp_ready
//           |           | rsp_text_length, rsp_last_of_run          |
//
// An input item is scanned in the cycle it is accepted; its tokens (zero to three)
// sit in the result queue from the next cycle on, one leaves per cycle while rsp_ready is high.
// The block takes one item per cycle as long as each item yields at most one token and
// rsp_ready stays high; the single result port sets the rate otherwise, at one token per cycle.
// Reset is synchronous and returns the scanner to the start of a new source with
// an empty queue. A stalled result port fills the four-entry queue, and input
// is held off while more than one entry is occupied.
module source_text_tokenizer #(
   parameter int OFFSET_BITS       = stt_pkg::OFFSET_BITS_DEFAULT,
   parameter int KEYWORD_MAX_CHARS = stt_pkg::KEYWORD_MAX_CHARS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_value,
   input  logic        req_has_byte,
   input  logic        req_end_of_source,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_token_type,
   output logic [15:0] rsp_start_offset,
   output logic [15:0] rsp_text_length,
   output logic        rsp_last_of_run
);

   localparam int QUEUE_DEPTH = 4;

   stt_pkg::scan_out_type scan_result;
   stt_pkg::rsp_item_type queue_ff [QUEUE_DEPTH];
   stt_pkg::rsp_item_type queue_in [QUEUE_DEPTH];
   logic [2:0]            count_ff, count_in;
   logic                  accept;
   logic                  pop;

   // Room for the three tokens that one item can cause must be there before it
   // is taken, so the check only looks at the current fill.
   assign req_ready = (count_ff <= 3'd1);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (count_ff != 3'd0);
   assign pop       = rsp_valid && rsp_ready;

   stt_scan #(
      .OFFSET_BITS       (OFFSET_BITS),
      .KEYWORD_MAX_CHARS (KEYWORD_MAX_CHARS)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .byte_value    (req_byte_value),
      .has_byte      (req_has_byte),
      .end_of_source (req_end_of_source),
      .result        (scan_result)
   );

   // The queue shifts toward the head on a pop; new tokens land right behind
   // whatever stays, and the last of them carries the end-of-run flag.
   always_comb begin
      logic [2:0] base;
      logic [2:0] push;

      base = count_ff - {2'b00, pop};
      push = accept ? {1'b0, scan_result.count} : 3'd0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (pop && i < QUEUE_DEPTH - 1) begin
            queue_in[i] = queue_ff[i + 1];
         end else begin
            queue_in[i] = queue_ff[i];
         end
         for (int k = 0; k < 3; k++) begin
            if (3'(k) < push && base + 3'(k) == 3'(i)) begin
               queue_in[i].tok  = scan_result.slot[k];
               queue_in[i].last = (3'(k) == push - 3'd1);
            end
         end
      end
      count_in = base + push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         queue_ff[i] <= queue_in[i];
      end
   end

   assign rsp_token_type   = queue_ff[0].tok.token_type;
   assign rsp_start_offset = queue_ff[0].tok.start_offset;
   assign rsp_text_length  = queue_ff[0].tok.text_length;
   assign rsp_last_of_run  = queue_ff[0].last;

endmodule

// ===== design/stt_checker.sv =====
// Port-level checks of the source text tokenizer and their binding.
module stt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_byte_value,
   input logic        req_has_byte,
   input logic        req_end_of_source,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [4:0]  rsp_token_type,
   input logic [15:0] rsp_start_offset,
   input logic [15:0] rsp_text_length,
   input logic        rsp_last_of_run
);

   // A result item that waits keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_type)
         && $stable(rsp_start_offset) && $stable(rsp_text_length)
         && $stable(rsp_last_of_run))
      else $error("stalled result item changed");

   // The queue comes out of reset empty.
   assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // With nothing queued there is always room for a new input item.
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("input held off with an empty queue");

   // The tokens of one item are queued together, so a run never breaks off.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid)
      else $error("run of results broke off");

   // The end token has no text and closes its run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_type == stt_pkg::TOK_END |->
         rsp_text_length == 16'd0 && rsp_last_of_run)
      else $error("malformed end token");

endmodule

bind source_text_tokenizer stt_checker u_checker (.*);
